// File: hdl/spma_pkg.sv
`timescale 1ns / 1ps
package spma_pkg;

    localparam int MaxTermsDef   = 32;
    localparam int MaxExpDef     = 31;
    localparam int QueueDepthDef = 4;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_MUL = 1'b1;

    // Input beat
    typedef struct packed {
        logic               side;
        logic signed [15:0] coefficient;
        logic [4:0]         exponent;
        logic               final_req;
    } t_in;

    // Result beat
    typedef struct packed {
        logic signed [39:0] result_coefficient;
        logic [5:0]         result_exponent;
        logic               last;
        logic               empty_res;
        logic               overflow;
    } t_out;

    // Classified term, front to back
    typedef struct packed {
        logic               keep;  // write into the term store
        logic               side;
        logic signed [15:0] coef;
        logic [4:0]         exp;
        logic               fin;   // run ends here, start the computation
        logic               ovf;   // some term of this run was dropped
        logic               op;    // operation for this run
    } t_entry;

endpackage

// File: hdl/sparse_polynomial_multiply_add_core.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_ready   i_in_data   (spma_pkg::t_in)
// out      output     o_out_valid / i_out_ready o_out_data  (spma_pkg::t_out)
// cfg      input      i_cfg_valid / o_cfg_ready i_cfg_data  (operation bit)
//
// Term beats are taken one per cycle while the front queue has room; the back end
// stores terms only while idle. A final beat starts the run: every term pair
// (multiply: count_a * count_b) or term (add: count_a + count_b) passes the
// read, multiply, accumulator-read and add states, with one shared multiplier
// and an accumulator RAM read-modify-write; then the slot scan walks down from
// slot 2*MAX_EXP to the lowest present exponent (an empty result gives one beat).
// Reset (i_rst_n low, synchronous) clears counts, present bits and handshakes;
// the term stores and accumulator RAM need no clearing pass.
// The output register holds a beat until taken; the scan stalls on a full output.
module sparse_polynomial_multiply_add_core #(
    parameter int MAX_TERMS   = spma_pkg::MaxTermsDef,
    parameter int MAX_EXP     = spma_pkg::MaxExpDef,
    parameter int QUEUE_DEPTH = spma_pkg::QueueDepthDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  spma_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output spma_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_data
);
    // operation register, sampled into each term beat by the front end
    logic r_operation;

    logic             w_push, w_full, w_q_valid, w_pop;
    spma_pkg::t_entry w_push_entry, w_q_entry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_operation <= spma_pkg::OP_ADD;
        end else if (i_cfg_valid) begin
            r_operation <= i_cfg_data;
        end
    end

    // front end: drop checks and per-run overflow flag
    spma_front #(
        .MAX_TERMS (MAX_TERMS),
        .MAX_EXP   (MAX_EXP)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in_data),
        .i_op       (r_operation),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    // decouples intake from a run in progress
    spma_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_entry),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_entry),
        .i_pop   (w_pop)
    );

    // back end: term stores, multiply/accumulate and descending scan
    spma_back #(
        .MAX_TERMS (MAX_TERMS),
        .MAX_EXP   (MAX_EXP)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_entry),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );
endmodule

// File: hdl/spma_front.sv
`timescale 1ns / 1ps
module spma_front #(
    parameter int MAX_TERMS = spma_pkg::MaxTermsDef,
    parameter int MAX_EXP   = spma_pkg::MaxExpDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  spma_pkg::t_in   i_in,
    input  logic            i_op,
    input  logic            i_q_full,
    output logic            o_push,
    output spma_pkg::t_entry o_entry
);
    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    logic [CNT_W-1:0] r_cnt_a, r_cnt_b;
    logic             r_drop;
    logic             w_full_side;
    logic             w_drop;
    logic             w_acc;

    // Capacity and exponent check, tracked here so the back end never stores a bad term
    assign w_full_side = i_in.side ? (r_cnt_b == CNT_W'(MAX_TERMS))
                                   : (r_cnt_a == CNT_W'(MAX_TERMS));
    assign w_drop      = (i_in.exponent > 5'(MAX_EXP)) || w_full_side;
    assign o_in_ready  = !i_q_full;
    assign w_acc       = i_in_valid && !i_q_full;
    assign o_push      = w_acc;

    always_comb begin
        o_entry.keep = !w_drop;
        o_entry.side = i_in.side;
        o_entry.coef = i_in.coefficient;
        o_entry.exp  = i_in.exponent;
        o_entry.fin  = i_in.final_req;
        o_entry.ovf  = r_drop || w_drop;
        o_entry.op   = i_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_drop  <= 1'b0;
        end else if (w_acc) begin
            if (i_in.final_req) begin
                r_cnt_a <= '0;
                r_cnt_b <= '0;
                r_drop  <= 1'b0;
            end else if (w_drop) begin
                r_drop <= 1'b1;
            end else if (i_in.side) begin
                r_cnt_b <= r_cnt_b + CNT_W'(1);
            end else begin
                r_cnt_a <= r_cnt_a + CNT_W'(1);
            end
        end
    end
endmodule

// File: hdl/spma_queue.sv
`timescale 1ns / 1ps
module spma_queue #(
    parameter int DEPTH = spma_pkg::QueueDepthDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  spma_pkg::t_entry i_data,
    output logic             o_full,
    output logic             o_valid,
    output spma_pkg::t_entry o_data,
    input  logic             i_pop
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    spma_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end
endmodule

// File: hdl/spma_back.sv
`timescale 1ns / 1ps
module spma_back #(
    parameter int MAX_TERMS = spma_pkg::MaxTermsDef,
    parameter int MAX_EXP   = spma_pkg::MaxExpDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  spma_pkg::t_entry i_q_data,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output spma_pkg::t_out   o_out
);
    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int IDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int NSLOT  = 2 * MAX_EXP + 1;
    localparam int SLOT_W = $clog2(NSLOT);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_START = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_ARD   = 4'd4;
    localparam logic [3:0] ST_ADD   = 4'd5;
    localparam logic [3:0] ST_SCAN0 = 4'd6;
    localparam logic [3:0] ST_SCAN  = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;
    localparam logic [3:0] ST_EMPTY = 4'd9;

    localparam logic signed [40:0] SAT_MAX = 41'sh0_7F_FFFF_FFFF;
    localparam logic signed [40:0] SAT_MIN = -41'sh0_80_0000_0000;

    // term stores
    logic signed [15:0] r_a_coef_mem [MAX_TERMS];
    logic [4:0]         r_a_exp_mem  [MAX_TERMS];
    logic signed [15:0] r_b_coef_mem [MAX_TERMS];
    logic [4:0]         r_b_exp_mem  [MAX_TERMS];
    logic signed [15:0] r_a_coef, r_b_coef;
    logic [4:0]         r_a_exp, r_b_exp;

    // accumulators
    logic signed [39:0] r_acc_mem [NSLOT];
    logic signed [39:0] r_acc_q;
    logic [NSLOT-1:0]   r_present, n_present;

    logic [3:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [IDX_W-1:0]   r_i, n_i, r_j, n_j;
    logic               r_ph, n_ph;
    logic               r_op, n_op;
    logic               r_ovf, n_ovf;
    logic [SLOT_W-1:0]  r_k, n_k;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic signed [31:0] r_prod, n_prod;
    logic               r_out_valid, n_out_valid;
    spma_pkg::t_out     r_out, n_out;

    logic               w_wr_a, w_wr_b;
    logic [SLOT_W-1:0]  w_acc_raddr;
    logic               w_acc_we;
    logic signed [39:0] w_old;
    logic signed [40:0] w_sum;
    logic signed [39:0] w_sat;
    logic               w_i_last, w_j_last;
    logic               w_free;
    logic [NSLOT-1:0]   w_below;
    logic               w_last;
    logic signed [15:0] w_sel;

    assign o_pop       = (r_state == ST_IDLE) && i_q_valid;
    assign w_wr_a      = o_pop && i_q_data.keep && !i_q_data.side;
    assign w_wr_b      = o_pop && i_q_data.keep && i_q_data.side;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (w_wr_a) begin
            r_a_coef_mem[r_cnt_a[IDX_W-1:0]] <= i_q_data.coef;
            r_a_exp_mem[r_cnt_a[IDX_W-1:0]]  <= i_q_data.exp;
        end
        if (w_wr_b) begin
            r_b_coef_mem[r_cnt_b[IDX_W-1:0]] <= i_q_data.coef;
            r_b_exp_mem[r_cnt_b[IDX_W-1:0]]  <= i_q_data.exp;
        end
        r_a_coef <= r_a_coef_mem[r_i];
        r_a_exp  <= r_a_exp_mem[r_i];
        r_b_coef <= r_b_coef_mem[r_j];
        r_b_exp  <= r_b_exp_mem[r_j];
    end

    // scan reads by slot index, accumulation by the product's slot
    assign w_acc_raddr = ((r_state == ST_SCAN) || (r_state == ST_EMIT)) ? r_k : r_slot;

    always_ff @(posedge i_clk) begin
        if (w_acc_we) begin
            r_acc_mem[r_slot] <= w_sat;
        end
        r_acc_q <= r_acc_mem[w_acc_raddr];
    end

    // saturating add, an absent slot reads as zero
    always_comb begin
        w_old = r_present[r_slot] ? r_acc_q : '0;
        w_sum = {w_old[39], w_old} + {{9{r_prod[31]}}, r_prod};
        if (w_sum > SAT_MAX) begin
            w_sat = SAT_MAX[39:0];
        end else if (w_sum < SAT_MIN) begin
            w_sat = SAT_MIN[39:0];
        end else begin
            w_sat = w_sum[39:0];
        end
    end

    always_comb begin
        for (int b = 0; b < NSLOT; b++) begin
            w_below[b] = r_present[b] && (SLOT_W'(b) < r_k);
        end
    end

    assign w_last   = (w_below == '0);
    assign w_i_last = (CNT_W'(r_i) + CNT_W'(1)) == r_cnt_a;
    assign w_j_last = (CNT_W'(r_j) + CNT_W'(1)) == r_cnt_b;
    assign w_free   = !r_out_valid || i_out_ready;
    assign w_sel    = r_ph ? r_b_coef : r_a_coef;

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_i         = r_i;
        n_j         = r_j;
        n_ph        = r_ph;
        n_op        = r_op;
        n_ovf       = r_ovf;
        n_k         = r_k;
        n_slot      = r_slot;
        n_prod      = r_prod;
        n_present   = r_present;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_acc_we    = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (w_wr_a) begin
                        n_cnt_a = r_cnt_a + CNT_W'(1);
                    end
                    if (w_wr_b) begin
                        n_cnt_b = r_cnt_b + CNT_W'(1);
                    end
                    if (i_q_data.fin) begin
                        n_op    = i_q_data.op;
                        n_ovf   = i_q_data.ovf;
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                n_i  = '0;
                n_j  = '0;
                n_ph = 1'b0;
                if (r_op == spma_pkg::OP_MUL) begin
                    n_state = ((r_cnt_a != '0) && (r_cnt_b != '0)) ? ST_RD : ST_SCAN0;
                end else if (r_cnt_a != '0) begin
                    n_state = ST_RD;
                end else if (r_cnt_b != '0) begin
                    n_ph    = 1'b1;
                    n_state = ST_RD;
                end else begin
                    n_state = ST_SCAN0;
                end
            end
            ST_RD: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_op == spma_pkg::OP_MUL) begin
                    n_prod = r_a_coef * r_b_coef;
                    n_slot = SLOT_W'(r_a_exp) + SLOT_W'(r_b_exp);
                end else begin
                    // Q8.8 to Q16.16
                    n_prod = {{8{w_sel[15]}}, w_sel, 8'h00};
                    n_slot = r_ph ? SLOT_W'(r_b_exp) : SLOT_W'(r_a_exp);
                end
                n_state = ST_ARD;
            end
            ST_ARD: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                w_acc_we          = 1'b1;
                n_present[r_slot] = 1'b1;
                n_state           = ST_RD;
                if (r_op == spma_pkg::OP_MUL) begin
                    if (!w_j_last) begin
                        n_j = r_j + IDX_W'(1);
                    end else begin
                        n_j = '0;
                        if (!w_i_last) begin
                            n_i = r_i + IDX_W'(1);
                        end else begin
                            n_state = ST_SCAN0;
                        end
                    end
                end else if (!r_ph) begin
                    if (!w_i_last) begin
                        n_i = r_i + IDX_W'(1);
                    end else if (r_cnt_b != '0) begin
                        n_ph = 1'b1;
                        n_j  = '0;
                    end else begin
                        n_state = ST_SCAN0;
                    end
                end else if (!w_j_last) begin
                    n_j = r_j + IDX_W'(1);
                end else begin
                    n_state = ST_SCAN0;
                end
            end
            ST_SCAN0: begin
                n_k     = SLOT_W'(NSLOT - 1);
                n_state = (r_present == '0) ? ST_EMPTY : ST_SCAN;
            end
            ST_SCAN: begin
                if (r_present[r_k]) begin
                    n_state = ST_EMIT;
                end else if (r_k == '0) begin
                    n_present = '0;
                    n_cnt_a   = '0;
                    n_cnt_b   = '0;
                    n_state   = ST_IDLE;
                end else begin
                    n_k = r_k - SLOT_W'(1);
                end
            end
            ST_EMIT: begin
                if (w_free) begin
                    n_out_valid              = 1'b1;
                    n_out.result_coefficient = r_acc_q;
                    n_out.result_exponent    = 6'(r_k);
                    n_out.last               = w_last;
                    n_out.empty_res          = 1'b0;
                    n_out.overflow           = r_ovf;
                    if (w_last) begin
                        n_present = '0;
                        n_cnt_a   = '0;
                        n_cnt_b   = '0;
                        n_state   = ST_IDLE;
                    end else begin
                        n_k     = r_k - SLOT_W'(1);
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_EMPTY: begin
                if (w_free) begin
                    n_out_valid              = 1'b1;
                    n_out.result_coefficient = '0;
                    n_out.result_exponent    = '0;
                    n_out.last               = 1'b1;
                    n_out.empty_res          = 1'b1;
                    n_out.overflow           = r_ovf;
                    n_cnt_a                  = '0;
                    n_cnt_b                  = '0;
                    n_state                  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_ph        <= 1'b0;
            r_op        <= spma_pkg::OP_ADD;
            r_ovf       <= 1'b0;
            r_k         <= '0;
            r_present   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_i         <= n_i;
            r_j         <= n_j;
            r_ph        <= n_ph;
            r_op        <= n_op;
            r_ovf       <= n_ovf;
            r_k         <= n_k;
            r_present   <= n_present;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_prod <= n_prod;
        r_out  <= n_out;
    end
endmodule
